[hdl/cct_pkg.sv]
// ----------------------------------------------------------------------------
// cct_pkg: shared types, codes and tables of the character class tokenizer
// Holds the class codes, the result record, the keyword table and the
// character classifier used by the tokenizer core.
// ----------------------------------------------------------------------------
package cct_pkg;

	// Class codes; KEYWORD through ERROR appear on the output, OTHER and NONE
	// are internal (a dropped byte and "no run open").
	typedef enum logic [3:0] {
		CL_KEYWORD  = 4'd0,
		CL_TEXT     = 4'd1,
		CL_NUMBER   = 4'd2,
		CL_OPERATOR = 4'd3,
		CL_COMMENT  = 4'd4,
		CL_STRING   = 4'd5,
		CL_NEWLINE  = 4'd6,
		CL_OPEN     = 4'd7,
		CL_CLOSE    = 4'd8,
		CL_ERROR    = 4'd9,
		CL_OTHER    = 4'd10,
		CL_NONE     = 4'd15
	} cls_t;

	localparam int          MAX_RES   = 3;
	localparam int          KW_COUNT  = 10;
	localparam logic [2:0]  KW_BYTES  = 3'd6;
	localparam logic [2:0]  KW_SAT    = 3'd7;
	localparam logic [15:0] ERR_POS   = 16'hFFFF;
	localparam int          TDATA_W   = 48;

	// Keywords packed right-aligned, first character in the highest used byte.
	localparam logic [47:0] KW_WORD [KW_COUNT] = '{
		48'h0077_6869_6C65,         // while
		48'h0000_7479_7065,         // type
		48'h0000_6675_6E63,         // func
		48'h0000_0076_6172,         // var
		48'h0000_006E_6577,         // new
		48'h0075_7369_6E67,         // using
		48'h7374_6174_6963,         // static
		48'h7265_7475_726E,         // return
		48'h0000_0000_6966,         // if
		48'h0000_656C_7365          // else
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd5, 3'd4, 3'd4, 3'd3, 3'd3, 3'd5, 3'd6, 3'd6, 3'd2, 3'd4
	};

	typedef struct packed {
		logic [3:0]  token_class;
		logic [15:0] start_pos;
		logic [16:0] token_len;
		logic [4:0]  nest_depth;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] slot;
		logic [1:0]         cnt;
	} bundle_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} stk_ctl_t;

	function automatic cls_t classify(logic [7:0] c, logic group_open);
		cls_t r;
		if (c inside {[8'd65:8'd90], [8'd97:8'd122], 8'd95}) r = CL_TEXT;
		else if (c inside {[8'd48:8'd57]}) r = CL_NUMBER;
		else if (c == 8'd40) r = CL_OPEN;
		else if (c == 8'd41) r = group_open ? CL_CLOSE : CL_OPERATOR;
		else if (c == 8'd35) r = CL_COMMENT;
		else if (c == 8'd34) r = CL_STRING;
		else if (c inside {[8'd33:8'd47], [8'd58:8'd63], 8'd94, 8'd124, 8'd126})
			r = CL_OPERATOR;
		else if (c == 8'd10) r = CL_NEWLINE;
		else r = CL_OTHER;
		return r;
	endfunction

	function automatic logic kw_match(logic [47:0] buf_w, logic [2:0] cnt);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (buf_w == KW_WORD[k] && cnt == KW_LEN[k]) hit = 1'b1;
		end
		return hit;
	endfunction

	function automatic res_t mk_res(cls_t c, logic [15:0] s, logic [16:0] l, logic [4:0] d);
		res_t r;
		r.token_class = c;
		r.start_pos   = s;
		r.token_len   = l;
		r.nest_depth  = d;
		return r;
	endfunction

endpackage

[hdl/cct_stack.sv]
// ----------------------------------------------------------------------------
// cct_stack: open-group position stack
// Keeps the open depth, a registered copy of the top entry and of the
// outermost entry; deeper entries live in a small memory.
// ----------------------------------------------------------------------------
module cct_stack #(
	parameter int DEPTH = 16,
	parameter int DW    = 17,
	parameter int DC_W  = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cct_pkg::stk_ctl_t ctl,
	input  logic [DW-1:0]     wdata,
	output logic [DC_W-1:0]   depth,
	output logic [DW-1:0]     top,
	output logic [DW-1:0]     bottom
);
	import cct_pkg::*;

	localparam int DI_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DW-1:0]   mem [DEPTH];
	logic [DC_W-1:0] depth_q;
	logic [DW-1:0]   top_q;
	logic [DW-1:0]   bottom_q;
	logic [DC_W-1:0] below_idx;
	logic            has_below;

	assign below_idx = depth_q - DC_W'(2);
	assign has_below = {1'b0, depth_q} >= (DC_W + 1)'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (ctl.clear) begin
			depth_q <= '0;
		end else if (ctl.push) begin
			depth_q <= depth_q + DC_W'(1);
		end else if (ctl.pop) begin
			depth_q <= depth_q - DC_W'(1);
		end
	end

	// The top entry is the memory's registered read port; a push forwards.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[depth_q[DI_W-1:0]] <= wdata;
			top_q <= wdata;
			if (depth_q == '0) bottom_q <= wdata;
		end else if (ctl.pop && has_below) begin
			top_q <= mem[below_idx[DI_W-1:0]];
		end
	end

	assign depth  = depth_q;
	assign top    = top_q;
	assign bottom = bottom_q;

endmodule

[hdl/cct_core.sv]
// ----------------------------------------------------------------------------
// cct_core: run tracking and result generation
// Classifies one character, extends or closes the open run, handles groups
// and end of input, and packs up to three results into a bundle.
// ----------------------------------------------------------------------------
module cct_core #(
	parameter int MAX_LEN   = 65536,
	parameter int MAX_DEPTH = 16,
	parameter int POS_W     = 17,
	parameter int DC_W      = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [7:0]         ch,
	input  logic               last,
	input  logic [DC_W-1:0]    depth,
	input  logic [POS_W-1:0]   top,
	input  logic [POS_W-1:0]   bottom,
	output cct_pkg::stk_ctl_t  ctl,
	output logic [POS_W-1:0]   wdata,
	output cct_pkg::bundle_t   bundle
);
	import cct_pkg::*;

	localparam int LW = (POS_W > 17) ? POS_W : 17;
	localparam int SW = (POS_W > 16) ? POS_W : 16;
	localparam int EW = (DC_W > 5) ? DC_W : 5;

	logic [POS_W-1:0] pos_q, pos_n;
	cls_t             rc_q, rc_n;
	logic [POS_W-1:0] rs_q, rs_n;
	logic [47:0]      kb_q, kb_n;
	logic [2:0]       kc_q, kc_n;

	cls_t             cls;
	logic             runnable;
	logic             ovf;
	logic [DC_W-1:0]  d_n;
	logic [POS_W-1:0] bot_n;
	res_t             cand [4];
	logic [3:0]       cv;
	logic [1:0]       n;

	function automatic logic [16:0] len_of(logic [POS_W-1:0] e, logic [POS_W-1:0] s);
		logic [LW-1:0] w;
		w = LW'(e) - LW'(s);
		return w[16:0];
	endfunction

	function automatic logic [15:0] start_of(logic [POS_W-1:0] s);
		logic [SW-1:0] w;
		w = SW'(s);
		return w[15:0];
	endfunction

	function automatic logic [4:0] dep_of(logic [DC_W-1:0] d);
		logic [EW-1:0] w;
		w = EW'(d);
		return w[4:0];
	endfunction

	function automatic cls_t run_cls(cls_t c, logic [47:0] b, logic [2:0] k);
		return (c == CL_TEXT && kw_match(b, k)) ? CL_KEYWORD : c;
	endfunction

	always_comb begin
		cls      = classify(ch, depth != '0);
		runnable = cls <= CL_NEWLINE;
		ovf      = pos_q == POS_W'(MAX_LEN);
		pos_n    = pos_q;
		rc_n     = rc_q;
		rs_n     = rs_q;
		kb_n     = kb_q;
		kc_n     = kc_q;
		d_n      = depth;
		bot_n    = bottom;
		ctl      = '0;
		wdata    = pos_q;
		cv       = '0;
		for (int i = 0; i < 4; i++) cand[i] = '0;

		if (ovf) begin
			// Past the length limit: drop the byte, keep any open run.
			cv[1]   = 1'b1;
			cand[1] = mk_res(CL_ERROR, ERR_POS, 17'd0, dep_of(depth));
		end else begin
			pos_n = pos_q + POS_W'(1);
			if (runnable && cls == rc_q) begin
				if (kc_q < KW_BYTES) begin
					kb_n = {kb_q[39:0], ch};
					kc_n = kc_q + 3'd1;
				end else begin
					kc_n = KW_SAT;
				end
			end else begin
				if (rc_q != CL_NONE) begin
					cv[0]   = 1'b1;
					cand[0] = mk_res(run_cls(rc_q, kb_q, kc_q), start_of(rs_q),
						len_of(pos_q, rs_q), dep_of(depth));
					rc_n    = CL_NONE;
				end
				if (cls == CL_OPEN) begin
					cv[1] = 1'b1;
					if (depth != DC_W'(MAX_DEPTH)) begin
						cand[1]  = mk_res(CL_OPEN, start_of(pos_q), 17'd1, dep_of(depth));
						ctl.push = 1'b1;
						d_n      = depth + DC_W'(1);
						if (depth == '0) bot_n = pos_q;
					end else begin
						cand[1] = mk_res(CL_ERROR, start_of(pos_q), 17'd1, dep_of(depth));
					end
				end else if (cls == CL_CLOSE) begin
					cv[1]   = 1'b1;
					ctl.pop = 1'b1;
					d_n     = depth - DC_W'(1);
					cand[1] = mk_res(CL_CLOSE, start_of(top),
						len_of(pos_q + POS_W'(1), top), dep_of(d_n));
				end else if (runnable) begin
					rc_n = cls;
					rs_n = pos_q;
					kb_n = {40'd0, ch};
					kc_n = 3'd1;
				end
			end
		end

		if (last) begin
			ctl.clear = 1'b1;
			if (rc_n != CL_NONE) begin
				cv[2]   = 1'b1;
				cand[2] = mk_res(run_cls(rc_n, kb_n, kc_n), start_of(rs_n),
					len_of(pos_n, rs_n), dep_of(d_n));
			end
			if (d_n != '0) begin
				cv[3]   = 1'b1;
				cand[3] = mk_res(CL_ERROR, start_of(bot_n), len_of(pos_n, bot_n),
					dep_of(d_n));
			end
		end

		if (!adv) ctl = '0;
	end

	// Pack the present candidates into the result slots in order.
	always_comb begin
		bundle = '0;
		n      = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (cv[i] && n != 2'(MAX_RES)) begin
				bundle.slot[n] = cand[i];
				n = n + 2'd1;
			end
		end
		bundle.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			rc_q  <= CL_NONE;
			rs_q  <= '0;
			kb_q  <= '0;
			kc_q  <= '0;
		end else if (adv) begin
			if (last) begin
				pos_q <= '0;
				rc_q  <= CL_NONE;
				rs_q  <= '0;
				kb_q  <= '0;
				kc_q  <= '0;
			end else begin
				pos_q <= pos_n;
				rc_q  <= rc_n;
				rs_q  <= rs_n;
				kb_q  <= kb_n;
				kc_q  <= kc_n;
			end
		end
	end

endmodule

[hdl/cct_out.sv]
// ----------------------------------------------------------------------------
// cct_out: result register and output serializer
// Holds the results of one character and sends them one transfer at a time.
// ----------------------------------------------------------------------------
module cct_out (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  cct_pkg::bundle_t               bundle,
	output logic                           free,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [cct_pkg::TDATA_W-1:0]    m_axis_tdata,
	output logic                           m_axis_tlast
);
	import cct_pkg::*;

	bundle_t    b_q;
	logic       valid_q;
	logic [1:0] idx_q;
	res_t       cur;

	assign cur           = b_q.slot[idx_q];
	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast  = idx_q == b_q.cnt - 2'd1;
	assign m_axis_tdata  = {(TDATA_W - 42)'(0), cur.nest_depth, cur.token_len,
		cur.start_pos, cur.token_class};
	assign free          = !valid_q || (m_axis_tready && m_axis_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && m_axis_tready) begin
			if (m_axis_tlast) valid_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) b_q <= bundle;
	end

endmodule

[hdl/char_class_run_tokenizer.sv]
// ----------------------------------------------------------------------------
// char_class_run_tokenizer: streaming character class tokenizer
// Turns a byte stream of source text into tokens, one token per transfer.
// ----------------------------------------------------------------------------
// One source character enters per transfer on the slave side, with tlast on
// the final character of a source. A character passes an input register,
// then is classified, extends or ends the open run and updates the group
// stack; the zero to three tokens it causes are loaded into a result
// register and leave one transfer per cycle on the master side while the
// receiver is ready, the last token of a character carrying tlast. While
// the result register is emptied the next character is already accepted.
// An accepted character passes the input register and then the result
// register before its first token appears. After tlast all state returns
// to reset and the next character starts a new source.
// ----------------------------------------------------------------------------
module char_class_run_tokenizer #(
	parameter int MAX_LEN   = 65536,
	parameter int MAX_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Source characters.
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // [7:0] ch
	input  logic                        s_axis_tlast,  // last character of the source
	// Tokens.
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [3:0] token_class, [19:4] start_pos, [36:20] token_len,
	// [41:37] nest_depth, [47:42] zero
	output logic [cct_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                        m_axis_tlast   // last token of a character
);
	import cct_pkg::*;

	// Position must be able to reach MAX_LEN itself, which marks overflow.
	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam int DC_W  = $clog2(MAX_DEPTH + 1);

	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             last_s1;
	logic             adv;
	logic             free;
	bundle_t          bundle;
	stk_ctl_t         ctl;
	logic [POS_W-1:0] wdata;
	logic [DC_W-1:0]  depth;
	logic [POS_W-1:0] top;
	logic [POS_W-1:0] bottom;

	// A character is processed when its tokens (if any) find the result
	// register free or being emptied by the final transfer of this cycle.
	assign adv           = valid_s1 && (bundle.cnt == 2'd0 || free);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	cct_core #(
		.MAX_LEN   (MAX_LEN),
		.MAX_DEPTH (MAX_DEPTH),
		.POS_W     (POS_W),
		.DC_W      (DC_W)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ch     (ch_s1),
		.last   (last_s1),
		.depth  (depth),
		.top    (top),
		.bottom (bottom),
		.ctl    (ctl),
		.wdata  (wdata),
		.bundle (bundle)
	);

	// Group stack: start positions of the open parentheses.
	cct_stack #(
		.DEPTH (MAX_DEPTH),
		.DW    (POS_W),
		.DC_W  (DC_W)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.wdata  (wdata),
		.depth  (depth),
		.top    (top),
		.bottom (bottom)
	);

	cct_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv && bundle.cnt != 2'd0),
		.bundle        (bundle),
		.free          (free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

[dv/char_class_run_tokenizer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_class_run_tokenizer_tb: self-checking bench for the run tokenizer
// Streams short source texts into the tokenizer and predicts every token,
// including the group, keyword and error cases. It compares each token leaving
// the master side field by field against that prediction, while both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module char_class_run_tokenizer_tb;
	import cct_pkg::*;

	localparam int MAX_LEN       = 65536;
	localparam int MAX_DEPTH     = 16;
	localparam int TOKEN_LIMIT   = 3;
	localparam int KW_PREFIX     = 6;     // bytes of a text run kept for the keyword compare
	localparam int PHASE_CHARS   = 103;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 2000;  // cycles without any transfer before giving up
	localparam int DRAIN_CYCLES  = 16;
	localparam int MAX_REPORTS   = 10;

	// One predicted token, in the order of the master side fields.
	typedef struct {
		cls_t        cls;
		logic [15:0] start;
		logic [16:0] len;
		logic [4:0]  depth;
		logic        fin;
	} token_t;

	// ------------------------------------------------------------------------
	// Token scoreboard. note_char() runs the tokenizer prediction for one
	// accepted character and queues the tokens it causes; check_token()
	// compares one token from the master side against the oldest of them.
	// ------------------------------------------------------------------------
	class tokenizer_scoreboard;
		token_t       expected_tokens[$];
		token_t       step_tokens[$];
		int           mismatches;
		string        kw_text[10];
		logic [47:0]  kw_word[10];
		int unsigned  kw_len[10];
		// Tokenizer state.
		int unsigned  position;
		cls_t         run_class;
		int unsigned  run_start;
		logic [47:0]  kw_buf;
		int unsigned  open_depth;
		logic [15:0]  group_starts[MAX_DEPTH];

		function new();
			kw_text = '{"while", "type", "func", "var", "new",
				"using", "static", "return", "if", "else"};
			foreach (kw_text[k]) begin
				kw_word[k] = '0;
				for (int j = 0; j < kw_text[k].len(); j++)
					kw_word[k] = {kw_word[k][39:0], kw_text[k][j]};
				kw_len[k] = kw_text[k].len();
			end
			mismatches = 0;
			clear_state();
		endfunction

		function void clear_state();
			position   = 0;
			run_class  = CL_NONE;
			run_start  = 0;
			kw_buf     = '0;
			open_depth = 0;
			foreach (group_starts[i])
				group_starts[i] = '0;
		endfunction

		function cls_t char_class(logic [7:0] c);
			case (c)
				8'd10:  return CL_NEWLINE;
				8'd34:  return CL_STRING;
				8'd35:  return CL_COMMENT;
				8'd40:  return CL_OPEN;
				8'd41:  return (open_depth != 0) ? CL_CLOSE : CL_OPERATOR;
				8'd95:  return CL_TEXT;
				8'd94, 8'd124, 8'd126: return CL_OPERATOR;
				default: begin
					if ((c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122))
						return CL_TEXT;
					if (c >= 8'd48 && c <= 8'd57)
						return CL_NUMBER;
					if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd63))
						return CL_OPERATOR;
					return CL_OTHER;
				end
			endcase
		endfunction

		function bit is_keyword(int unsigned len);
			if (len == 0 || len > KW_PREFIX)
				return 1'b0;
			foreach (kw_word[k])
				if (kw_len[k] == len && kw_word[k] == kw_buf)
					return 1'b1;
			return 1'b0;
		endfunction

		function void add_token(cls_t c, int unsigned s, int unsigned l, int unsigned d);
			token_t t;
			if (step_tokens.size() >= TOKEN_LIMIT)
				return;
			t.cls   = c;
			t.start = s[15:0];
			t.len   = l[16:0];
			t.depth = d[4:0];
			t.fin   = 1'b0;
			step_tokens = {step_tokens, t};
		endfunction

		// Emits the open run, if any, as ending just before end_pos.
		function void close_run(int unsigned end_pos);
			cls_t c;
			if (run_class == CL_NONE)
				return;
			c = run_class;
			if (c == CL_TEXT && is_keyword(end_pos - run_start))
				c = CL_KEYWORD;
			add_token(c, run_start, end_pos - run_start, open_depth);
			run_class = CL_NONE;
		endfunction

		function void note_char(logic [7:0] c, logic lst);
			int unsigned p;
			int unsigned s;
			cls_t        cl;
			bit          runnable;
			step_tokens.delete();
			if (position >= MAX_LEN) begin
				// Past the position limit the byte is dropped; an open run stays open.
				add_token(CL_ERROR, 16'hFFFF, 0, open_depth);
			end else begin
				p        = position;
				cl       = char_class(c);
				runnable = (cl <= CL_NEWLINE);
				if (runnable && cl == run_class) begin
					if (p - run_start < KW_PREFIX)
						kw_buf = {kw_buf[39:0], c};
				end else begin
					close_run(p);
					if (cl == CL_OPEN) begin
						if (open_depth < MAX_DEPTH) begin
							add_token(CL_OPEN, p, 1, open_depth);
							group_starts[open_depth] = p[15:0];
							open_depth++;
						end else begin
							add_token(CL_ERROR, p, 1, open_depth);
						end
					end else if (cl == CL_CLOSE) begin
						open_depth--;
						s = group_starts[open_depth % MAX_DEPTH];
						add_token(CL_CLOSE, s, p - s + 1, open_depth);
					end else if (runnable) begin
						run_class = cl;
						run_start = p;
						kw_buf    = {40'd0, c};
					end
				end
				position = p + 1;
			end
			if (lst) begin
				close_run(position);
				if (open_depth != 0) begin
					s = group_starts[0];
					add_token(CL_ERROR, s, position - s, open_depth);
				end
				clear_state();
			end
			if (step_tokens.size() != 0)
				step_tokens[step_tokens.size() - 1].fin = 1'b1;
			foreach (step_tokens[i])
				expected_tokens = {expected_tokens, step_tokens[i]};
		endfunction

		function void check_token(logic [47:0] d, logic tl);
			token_t e;
			if (expected_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected token: class %0d start %0d len %0d depth %0d last %0b",
						d[3:0], d[19:4], d[36:20], d[41:37], tl);
				return;
			end
			e = expected_tokens.pop_front();
			if (d[3:0] !== e.cls || d[19:4] !== e.start || d[36:20] !== e.len ||
					d[41:37] !== e.depth || d[47:42] !== 6'd0 || tl !== e.fin) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("token mismatch: expected class %0d start %0d len %0d depth %0d last %0b",
						e.cls, e.start, e.len, e.depth, e.fin);
					$display("  got class %0d start %0d len %0d depth %0d last %0b pad %0h",
						d[3:0], d[19:4], d[36:20], d[41:37], tl, d[47:42]);
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the block under test. Every input starts known.
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	char_class_run_tokenizer #(
		.MAX_LEN   (MAX_LEN),
		.MAX_DEPTH (MAX_DEPTH)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	tokenizer_scoreboard sb;
	int          src_idle_pct = 0;   // chance per cycle that the sender holds back
	int          rx_stall_pct = 0;   // chance per cycle that the receiver stalls
	logic        rx_hold      = 1'b0;
	int          chars_sent   = 0;
	int          idle_cycles  = 0;
	logic [7:0]  src_chars[$];

	// ------------------------------------------------------------------------
	// Receiver. Ready is drawn anew every cycle; rx_hold forces a long stall
	// so that tokens pile up inside the block and it stops taking characters.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		m_axis_tready <= arst_n && !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	// ------------------------------------------------------------------------
	// Monitor. Both sides are sampled at the clock edge, before the block's
	// registers move, so an accepted character is always noted before any
	// token it causes can appear.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_char(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_token(m_axis_tdata, m_axis_tlast);
		end
	end

	// Watchdog: a run of cycles with no transfer on either side ends the test.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender. One character per transfer; valid stays high between back to
	// back characters and only drops for a random gap.
	// ------------------------------------------------------------------------
	task automatic send_char(logic [7:0] c, logic lst);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		chars_sent++;
	endtask

	// Appends one character to the source being built.
	function automatic void add_char(logic [7:0] c);
		src_chars = {src_chars, c};
	endfunction

	function automatic void add_text(string s);
		foreach (s[i])
			add_char(s[i]);
	endfunction

	// Sends the collected characters; tlast marks the final one when asked.
	task automatic send_source(bit with_last);
		foreach (src_chars[i])
			send_char(src_chars[i], with_last && i == src_chars.size() - 1);
		src_chars.delete();
	endtask

	// Builds a random source text from pieces of real token shapes, with some
	// raw byte noise. A deep source nests past the group stack limit.
	function automatic void build_source(bit deep);
		string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
		string op_chars    = "!$%&'*+,-./:;<=>?^|~";
		string word;
		int    pieces;
		int    n;
		pieces = $urandom_range(2, 10);
		if (deep) begin
			n = $urandom_range(MAX_DEPTH + 1, MAX_DEPTH + 3);
			repeat (n) begin
				add_char("(");
				if ($urandom_range(2) == 0)
					add_char(ident_chars[$urandom_range(ident_chars.len() - 1)]);
			end
		end
		repeat (pieces) begin
			case ($urandom_range(11))
				0, 1: begin
					// A keyword, sometimes extended or cut short into a plain word.
					word = sb.kw_text[$urandom_range(9)];
					case ($urandom_range(3))
						0: word = word.substr(0, word.len() - 2);
						1: word = {word, ident_chars.substr($urandom_range(52), $urandom_range(52))};
						default: ;
					endcase
					add_text(word);
				end
				2: repeat ($urandom_range(1, 8))
					add_char(ident_chars[$urandom_range(ident_chars.len() - 1)]);
				3: repeat ($urandom_range(1, 5))
					add_char(8'd48 + 8'($urandom_range(9)));
				4: repeat ($urandom_range(1, 3))
					add_char(op_chars[$urandom_range(op_chars.len() - 1)]);
				5: repeat ($urandom_range(1, 3))
					add_char("(");
				6: repeat ($urandom_range(1, 3))
					add_char(")");
				7: add_char($urandom_range(1) ? 8'd32 : 8'd9);
				8: repeat ($urandom_range(1, 2))
					add_char(8'd10);
				9: add_char($urandom_range(1) ? 8'd35 : 8'd34);
				default: add_char(8'($urandom_range(255)));
			endcase
			if ($urandom_range(3) == 0)
				add_char(8'd32);
		end
	endfunction

	// Runs random sources until the phase has moved its share of characters.
	// About one source in six ends without tlast and runs into the next one.
	task automatic run_phase(int idle_pct, int stall_pct, bit first_deep);
		int start_count;
		bit deep;
		src_idle_pct = idle_pct;
		rx_stall_pct = stall_pct;
		start_count  = chars_sent;
		deep         = first_deep;
		while (chars_sent - start_count < PHASE_CHARS) begin
			build_source(deep || $urandom_range(19) == 0);
			send_source($urandom_range(5) != 0);
			deep = 1'b0;
		end
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sources. The first touches a keyword, a group, both extreme
		// bytes (dropped), a number, an operator, a string mark, a comment mark
		// and a newline. Then an unmatched close, groups left open at the end,
		// a source ending on a dropped byte, and a keyword flushed by tlast.
		add_text("if(x)");
		add_char(8'h00);
		add_char(8'hFF);
		add_text("9+\"#");
		add_char(8'd10);
		send_source(1'b1);
		add_text(")");
		send_source(1'b1);
		add_text("((a");
		send_source(1'b1);
		add_text(" ");
		send_source(1'b1);
		add_text("else");
		send_source(1'b1);

		// Random phases. The first one starts past the group stack limit and
		// holds the receiver off for a long stretch while characters keep
		// coming, so the block fills up and pushes back.
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		run_phase(0, 0, 1'b1);
		run_phase(57, 0, 1'b0);
		run_phase(0, 57, 1'b0);
		run_phase(16, 16, 1'b0);

		s_axis_tvalid <= 1'b0;

		while (sb.expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
